// ===== hdl/fir_filter_loadable_coeffs_unit_macros.svh =====
// ============================================================================
// Assertion macros for the loadable-coefficient FIR filter
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ============================================================================
`ifndef FIR_FILTER_LOADABLE_COEFFS_UNIT_MACROS_SVH
`define FIR_FILTER_LOADABLE_COEFFS_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FIR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/fir_flc_pkg.sv =====
// ============================================================================
// fir_flc_pkg
// Types and fixed constants of the loadable-coefficient FIR filter.
// ============================================================================
package fir_flc_pkg;

    localparam int TAP_INDEX_WIDTH = 6;

    typedef enum logic [3:0]
    {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

endpackage

// ===== hdl/fir_flc_ram.sv =====
// ============================================================================
// fir_flc_ram
// Generic single-clock RAM with one write port and one registered read port.
// ============================================================================
module fir_flc_ram
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 33
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/fir_filter_loadable_coeffs_unit.sv =====
// ============================================================================
// fir_filter_loadable_coeffs_unit
// Direct-form FIR filter with ORDER+1 taps and a loadable coefficient store.
// A sample transaction is swept one tap per cycle, drained and then emitted;
// no new item is accepted until its result has been registered for output.
// A held result delays the next one. A coefficient transaction is written
// without leaving the idle state. Reset clears the pointers, the tap counter,
// the control state and the valid bits of both memories, so every coefficient
// and every stored sample reads as zero.
// ============================================================================
module fir_filter_loadable_coeffs_unit
    import fir_flc_pkg::*;
#(
    parameter int ORDER        = 32,
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // sample_in, tap_index, tap_value, zero fill
    input  logic [((SAMPLE_WIDTH+TAP_INDEX_WIDTH+COEF_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // mode
    input  logic [0:0] s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // sample_out, zero fill
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

    `include "fir_filter_loadable_coeffs_unit_macros.svh"

    localparam int TAPS      = ORDER + 1;
    localparam int TAP_W     = $clog2(TAPS);
    localparam int IDX_W     = (TAP_W > TAP_INDEX_WIDTH) ? TAP_W : TAP_INDEX_WIDTH;
    localparam int PROD_W    = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int ACC_W     = PROD_W + TAP_W;
    localparam int OUT_DW    = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int IDX_LSB   = SAMPLE_WIDTH;
    localparam int VAL_LSB   = SAMPLE_WIDTH + TAP_INDEX_WIDTH;

    localparam logic [TAP_W-1:0]        LAST_TAP = TAP_W'(ORDER);
    localparam logic [IDX_W-1:0]        MAX_IDX  = IDX_W'(ORDER);
    localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) <<< (COEF_WIDTH - 2);
    localparam logic signed [ACC_W-1:0] OUT_MAX  = ACC_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [ACC_W-1:0] OUT_MIN  = -OUT_MAX - ACC_W'(1);

    state_t state_reg, state_next;

    logic [TAP_W-1:0] wp_reg, wp_next;
    logic [TAP_W-1:0] k_reg, k_next;
    logic [TAP_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [TAPS-1:0]  coef_vld_reg, coef_vld_next;
    logic [TAPS-1:0]  dly_vld_reg, dly_vld_next;
    logic             rd_v_reg, rd_v_next;
    logic             prod_v_reg, prod_v_next;
    logic             coef_hit_reg, coef_hit_next;
    logic             dly_hit_reg, dly_hit_next;
    logic             out_v_reg, out_v_next;

    logic signed [PROD_W-1:0]       prod_reg, prod_next;
    logic signed [ACC_W-1:0]        acc_reg, acc_next;
    logic signed [SAMPLE_WIDTH-1:0] out_reg, out_next;

    logic                    in_fire;
    logic                    sample_fire;
    logic                    coef_fire;
    logic [IDX_W-1:0]        tap_idx_ext;
    logic                    issue;
    logic [COEF_WIDTH-1:0]   coef_rd;
    logic [SAMPLE_WIDTH-1:0] dly_rd;
    logic signed [COEF_WIDTH-1:0]   coef_eff;
    logic signed [SAMPLE_WIDTH-1:0] dly_eff;
    logic signed [ACC_W-1:0] rounded;
    logic signed [ACC_W-1:0] shifted;
    logic signed [SAMPLE_WIDTH-1:0] saturated;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign sample_fire   = in_fire && !s_axis_tuser[0];
    assign tap_idx_ext   = IDX_W'(s_axis_tdata[VAL_LSB-1:IDX_LSB]);
    assign coef_fire     = in_fire && s_axis_tuser[0] && (tap_idx_ext <= MAX_IDX);
    assign issue         = (state_reg == ST_RUN);

    fir_flc_ram
    #(
        .WIDTH (COEF_WIDTH),
        .DEPTH (TAPS)
    )
    u_coef_ram
    (
        .clk     (clk),
        .wr_en   (coef_fire),
        .wr_addr (tap_idx_ext[TAP_W-1:0]),
        .wr_data (s_axis_tdata[VAL_LSB+COEF_WIDTH-1:VAL_LSB]),
        .rd_en   (issue),
        .rd_addr (k_reg),
        .rd_data (coef_rd)
    );

    fir_flc_ram
    #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (TAPS)
    )
    u_delay_ram
    (
        .clk     (clk),
        .wr_en   (sample_fire),
        .wr_addr (wp_reg),
        .wr_data (s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .rd_en   (issue),
        .rd_addr (rd_ptr_reg),
        .rd_data (dly_rd)
    );

    assign coef_eff = coef_hit_reg ? $signed(coef_rd) : '0;
    assign dly_eff  = dly_hit_reg ? $signed(dly_rd) : '0;

    assign rounded = acc_reg + HALF_LSB;
    assign shifted = rounded >>> (COEF_WIDTH - 1);

    always_comb
    begin
        priority if (shifted > OUT_MAX)
        begin
            saturated = OUT_MAX[SAMPLE_WIDTH-1:0];
        end
        else if (shifted < OUT_MIN)
        begin
            saturated = OUT_MIN[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            saturated = shifted[SAMPLE_WIDTH-1:0];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        wp_next       = wp_reg;
        k_next        = k_reg;
        rd_ptr_next   = rd_ptr_reg;
        coef_vld_next = coef_vld_reg;
        dly_vld_next  = dly_vld_reg;
        rd_v_next     = issue;
        prod_v_next   = rd_v_reg;
        coef_hit_next = coef_hit_reg;
        dly_hit_next  = dly_hit_reg;
        out_v_next    = out_v_reg && !m_axis_tready;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        out_next      = out_reg;

        if (coef_fire)
        begin
            coef_vld_next[tap_idx_ext[TAP_W-1:0]] = 1'b1;
        end

        if (rd_v_reg)
        begin
            prod_next = coef_eff * dly_eff;
        end
        if (prod_v_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_fire)
                begin
                    dly_vld_next[wp_reg] = 1'b1;
                    rd_ptr_next = wp_reg;
                    wp_next     = (wp_reg == LAST_TAP) ? '0 : wp_reg + TAP_W'(1);
                    k_next      = '0;
                    acc_next    = '0;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN:
            begin
                coef_hit_next = coef_vld_reg[k_reg];
                dly_hit_next  = dly_vld_reg[rd_ptr_reg];
                rd_ptr_next   = (rd_ptr_reg == '0) ? LAST_TAP : rd_ptr_reg - TAP_W'(1);
                if (k_reg == LAST_TAP)
                begin
                    k_next     = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + TAP_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!rd_v_reg && !prod_v_reg)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_v_reg || m_axis_tready)
                begin
                    out_next   = saturated;
                    out_v_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            wp_reg       <= '0;
            k_reg        <= '0;
            rd_ptr_reg   <= '0;
            coef_vld_reg <= '0;
            dly_vld_reg  <= '0;
            rd_v_reg     <= 1'b0;
            prod_v_reg   <= 1'b0;
            coef_hit_reg <= 1'b0;
            dly_hit_reg  <= 1'b0;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            wp_reg       <= wp_next;
            k_reg        <= k_next;
            rd_ptr_reg   <= rd_ptr_next;
            coef_vld_reg <= coef_vld_next;
            dly_vld_reg  <= dly_vld_next;
            rd_v_reg     <= rd_v_next;
            prod_v_reg   <= prod_v_next;
            coef_hit_reg <= coef_hit_next;
            dly_hit_reg  <= dly_hit_next;
            out_v_reg    <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        out_reg  <= out_next;
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = OUT_DW'($unsigned(out_reg));

    `FIR_ASSERT_NEXT(a_sample_starts_run,
        s_axis_tvalid && s_axis_tready && !s_axis_tuser[0],
        state_reg == ST_RUN,
        "An accepted sample transaction did not start the tap sweep.")

    `FIR_ASSERT_NOW(a_pointers_in_range,
        1'b1,
        (wp_reg <= LAST_TAP) && (rd_ptr_reg <= LAST_TAP) && (k_reg <= LAST_TAP),
        "A delay-line pointer or tap counter left the tap range.")

    `FIR_ASSERT_NOW(a_emit_after_drain,
        state_reg == ST_EMIT,
        !rd_v_reg && !prod_v_reg,
        "The result was formed while products were still in flight.")

    `FIR_ASSERT_NOW(a_result_from_emit,
        $rose(out_v_reg),
        $past(state_reg == ST_EMIT),
        "A result appeared without the emit step.")

endmodule
